@@ design/ljoa_pkg.sv @@
// shared types, constants and tables for the orientation-averaged lennard-jones core
package ljoa_pkg;

  typedef struct packed {
    logic [23:0] radius;
    logic [17:0] polar_angle;
    logic [18:0] azimuth_angle;
    logic [23:0] point_weight;
    logic        last_point;
  } item_t;

  typedef struct packed {
    logic signed [47:0] average_energy;
    logic               zero_weight;
    logic               saturated;
  } result_t;

  typedef struct packed {
    logic signed [23:0] centre_site_z;
    logic signed [23:0] side_site_x;
    logic signed [23:0] side_site_z;
    logic        [19:0] centre_sigma;
    logic        [23:0] centre_eps_times_four;
    logic        [19:0] side_sigma;
    logic        [23:0] side_eps_times_four;
  } cfg_t;

  // register indexes of the configuration port
  localparam logic [2:0] CFG_CENTRE_SITE_Z         = 3'd0;
  localparam logic [2:0] CFG_SIDE_SITE_X           = 3'd1;
  localparam logic [2:0] CFG_SIDE_SITE_Z           = 3'd2;
  localparam logic [2:0] CFG_CENTRE_SIGMA          = 3'd3;
  localparam logic [2:0] CFG_CENTRE_EPS_TIMES_FOUR = 3'd4;
  localparam logic [2:0] CFG_SIDE_SIGMA            = 3'd5;
  localparam logic [2:0] CFG_SIDE_EPS_TIMES_FOUR   = 3'd6;

  localparam int CORDIC_STEPS = 30;
  localparam int MUL_STEPS    = 16;
  localparam int DIV_STEPS    = 80;

  localparam logic signed [35:0] PI_Q30     = 36'sd3373259426;
  localparam logic signed [35:0] HALFPI_Q30 = 36'sd1686629713;
  localparam logic signed [35:0] TWOPI_Q30  = 36'sd6746518852;
  localparam logic signed [33:0] CORDIC_K   = 34'sd652032875;

  localparam logic [63:0] SAT_Q30   = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] EMAX      = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [39:0] WMAX      = 40'hFF_FFFF_FFFF;

  // arctangent of 2^-i in q2.30
  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd843314857;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043837;
      5'd3:  v = 30'd133525159;
      5'd4:  v = 30'd67021688;
      5'd5:  v = 30'd33543516;
      5'd6:  v = 30'd16775851;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194283;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048576;
      5'd11: v = 30'd524288;
      5'd12: v = 30'd262144;
      5'd13: v = 30'd131072;
      5'd14: v = 30'd65536;
      5'd15: v = 30'd32768;
      5'd16: v = 30'd16384;
      5'd17: v = 30'd8192;
      5'd18: v = 30'd4096;
      5'd19: v = 30'd2048;
      5'd20: v = 30'd1024;
      5'd21: v = 30'd512;
      5'd22: v = 30'd256;
      5'd23: v = 30'd128;
      5'd24: v = 30'd64;
      5'd25: v = 30'd32;
      5'd26: v = 30'd16;
      5'd27: v = 30'd8;
      5'd28: v = 30'd4;
      5'd29: v = 30'd2;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

@@ design/ljoa_front.sv @@
// front end: accepts quadrature points into a two-entry queue
module ljoa_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_ready,
  input  ljoa_pkg::item_t item,
  input  logic            pop,
  output logic            avail,
  output ljoa_pkg::item_t head
);

  ljoa_pkg::item_t slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign item_ready = (count != 2'd2);
  assign push       = item_valid && item_ready;
  assign avail      = (count != 2'd0);
  assign head       = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= item;
  end

endmodule

@@ design/ljoa_cordic.sv @@
// iterative cordic: sine and cosine in q2.30 of a q.16 angle, one step per cycle
module ljoa_cordic (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [18:0]        angle,
  output logic signed [33:0] sin_val,
  output logic signed [33:0] cos_val,
  output logic               busy,
  output logic               done
);

  logic signed [35:0] a_red;
  logic               neg_red;
  logic signed [33:0] x;
  logic signed [33:0] y;
  logic signed [35:0] a;
  logic               neg;
  logic [4:0]         step;
  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic signed [35:0] at;

  // reduce into [-pi/2, pi/2]
  always_comb begin
    logic signed [35:0] t;
    t = $signed({3'b000, angle, 14'd0});
    if (t >= ljoa_pkg::TWOPI_Q30) t = t - ljoa_pkg::TWOPI_Q30;
    if (t >= ljoa_pkg::TWOPI_Q30) t = t - ljoa_pkg::TWOPI_Q30;
    if (t > ljoa_pkg::PI_Q30) t = t - ljoa_pkg::TWOPI_Q30;
    neg_red = 1'b0;
    if (t > ljoa_pkg::HALFPI_Q30) begin
      t = ljoa_pkg::PI_Q30 - t;
      neg_red = 1'b1;
    end else if (t < -ljoa_pkg::HALFPI_Q30) begin
      t = -ljoa_pkg::PI_Q30 - t;
      neg_red = 1'b1;
    end
    a_red = t;
  end

  assign xs = x >>> step;
  assign ys = y >>> step;
  assign at = $signed({6'd0, ljoa_pkg::atan_q30(step)});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 5'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= 5'd0;
      end else if (busy) begin
        step <= step + 5'd1;
        if (step == 5'(ljoa_pkg::CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x   <= ljoa_pkg::CORDIC_K;
      y   <= 34'sd0;
      a   <= a_red;
      neg <= neg_red;
    end else if (busy) begin
      if (!a[35]) begin
        x <= x - ys;
        y <= y + xs;
        a <= a - at;
      end else begin
        x <= x + ys;
        y <= y - xs;
        a <= a + at;
      end
    end
  end

  assign sin_val = y;
  assign cos_val = neg ? -x : x;

endmodule

@@ design/ljoa_back.sv @@
// back end: sequencer with shared cordic, multiplier and divider, accumulation and result
module ljoa_back (
  input  logic              clk,
  input  logic              rst,
  input  ljoa_pkg::cfg_t    cfg,
  input  logic              q_avail,
  input  ljoa_pkg::item_t   q_head,
  output logic              q_pop,
  output logic              result_valid,
  input  logic              result_ready,
  output ljoa_pkg::result_t result
);

  typedef enum logic [22:0] {
    S_IDLE  = 23'd1 << 0,
    S_COR_T = 23'd1 << 1,
    S_COR_P = 23'd1 << 2,
    S_RS    = 23'd1 << 3,
    S_PX    = 23'd1 << 4,
    S_PY    = 23'd1 << 5,
    S_PZ    = 23'd1 << 6,
    S_SITE  = 23'd1 << 7,
    S_DX    = 23'd1 << 8,
    S_DY    = 23'd1 << 9,
    S_DZ    = 23'd1 << 10,
    S_S2    = 23'd1 << 11,
    S_Q     = 23'd1 << 12,
    S_Q2    = 23'd1 << 13,
    S_Q3    = 23'd1 << 14,
    S_Q6    = 23'd1 << 15,
    S_E     = 23'd1 << 16,
    S_NEXT  = 23'd1 << 17,
    S_CLIP  = 23'd1 << 18,
    S_C     = 23'd1 << 19,
    S_FIN   = 23'd1 << 20,
    S_AVG   = 23'd1 << 21,
    S_OUT   = 23'd1 << 22
  } state_t;

  localparam logic [1:0]         LAST_SITE = 2'd2;
  localparam logic signed [49:0] E50_MAX   = 50'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [65:0] ES66_MAX  = 66'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [47:0] E48_MAX   = 48'sh7FFF_FFFF_FFFF;

  function automatic logic signed [31:0] rnd30(input logic neg, input logic [127:0] p);
    logic signed [63:0] v;
    v = $signed(p[63:0]);
    if (neg) v = -v;
    v = v + 64'sd536870912;
    return 32'(v >>> 30);
  endfunction

  function automatic logic [63:0] mag34(input logic signed [33:0] v);
    logic [33:0] u;
    u = v[33] ? -v : v;
    return {30'd0, u};
  endfunction

  function automatic logic [63:0] mag32(input logic signed [31:0] v);
    logic [31:0] u;
    u = v[31] ? -v : v;
    return {32'd0, u};
  endfunction

  state_t state;

  // point data
  logic [23:0]        r;
  logic [18:0]        ph;
  logic [23:0]        w;
  logic               last;
  logic signed [33:0] st, ct, sp, cp;
  logic signed [31:0] rs, px, py, pz;
  logic [1:0]         site;
  logic [63:0]        d2;
  logic [63:0]        qv;
  logic [63:0]        q3;
  logic               dneg;
  logic signed [47:0] site_e;
  logic signed [49:0] esum;
  logic               eneg;
  logic signed [47:0] res_avg;
  logic               res_zero;

  // sweep state
  logic signed [63:0] energy_sum;
  logic [39:0]        weight_sum;
  logic               clip_seen;

  // cordic
  logic               cor_start;
  logic [18:0]        cor_angle;
  logic signed [33:0] cor_sin, cor_cos;
  logic               cor_busy, cor_done;

  // shared multiplier, four bits per cycle
  logic         mul_start;
  logic [63:0]  mul_a_in, mul_b_in;
  logic [63:0]  mul_a;
  logic [127:0] mul_p;
  logic [3:0]   mul_cnt;
  logic         mul_run, mul_done;
  logic [67:0]  mul_t;

  // shared restoring divider, one bit per cycle
  logic        div_start;
  logic [79:0] div_num_in;
  logic [63:0] div_den_in;
  logic [63:0] div_den;
  logic [63:0] div_rem;
  logic [79:0] div_nq;
  logic [6:0]  div_cnt;
  logic        div_run, div_done;
  logic [64:0] div_r2;
  logic        div_ge;

  // datapath helpers
  logic signed [31:0] rs_w;
  logic [97:0]        p30;
  logic               p30_sat;
  logic               q_sat;
  logic signed [63:0] diff_w;
  logic signed [47:0] e_w;
  logic               e_clip;
  logic signed [31:0] dx_w, dy_w, dz_w;
  logic [19:0]        sig_w;
  logic [23:0]        eps_w;
  logic               site_off;
  logic signed [47:0] eclip_w;
  logic               eclip_flag;
  logic signed [63:0] es_next_w;
  logic               es_sat;
  logic [39:0]        ws_next_w;
  logic               ws_sat;
  logic [62:0]        esmag;
  logic signed [47:0] avg_w;
  logic               avg_sat;
  logic               out_free;

  ljoa_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cor_start),
    .angle   (cor_angle),
    .sin_val (cor_sin),
    .cos_val (cor_cos),
    .busy    (cor_busy),
    .done    (cor_done)
  );

  assign q_pop     = (state == S_IDLE) && q_avail;
  assign cor_start = q_pop || ((state == S_COR_T) && cor_done);
  assign cor_angle = (state == S_IDLE) ? {1'b0, q_head.polar_angle} : ph;
  assign out_free  = !result_valid || result_ready;

  assign rs_w    = rnd30(st[33], mul_p);
  assign p30     = mul_p[127:30];
  assign p30_sat = p30 > {34'd0, ljoa_pkg::SAT_Q30};
  assign q_sat   = div_nq > {16'd0, ljoa_pkg::SAT_Q30};
  assign diff_w  = $signed(p30[63:0]) - $signed(q3);
  assign e_clip  = p30 > {34'd0, ljoa_pkg::EMAX};

  always_comb begin
    logic signed [47:0] mag;
    mag = e_clip ? E48_MAX : $signed(p30[47:0]);
    e_w = dneg ? -mag : mag;
  end

  // site geometry
  always_comb begin
    logic signed [31:0] cz, sx, sz;
    cz = $signed({{8{cfg.centre_site_z[23]}}, cfg.centre_site_z});
    sx = $signed({{8{cfg.side_site_x[23]}}, cfg.side_site_x});
    sz = $signed({{8{cfg.side_site_z[23]}}, cfg.side_site_z});
    dy_w = py;
    case (site)
      2'd0: begin
        dx_w  = px;
        dz_w  = pz - cz;
        sig_w = cfg.centre_sigma;
        eps_w = cfg.centre_eps_times_four;
      end
      2'd1: begin
        dx_w  = px - sx;
        dz_w  = pz - sz;
        sig_w = cfg.side_sigma;
        eps_w = cfg.side_eps_times_four;
      end
      default: begin
        dx_w  = px + sx;
        dz_w  = pz - sz;
        sig_w = cfg.side_sigma;
        eps_w = cfg.side_eps_times_four;
      end
    endcase
  end

  assign site_off = (eps_w == 24'd0) || (sig_w == 20'd0);

  // point energy clip
  always_comb begin
    eclip_flag = 1'b0;
    eclip_w    = esum[47:0];
    if (esum > E50_MAX) begin
      eclip_w    = E48_MAX;
      eclip_flag = 1'b1;
    end else if (esum < -E50_MAX) begin
      eclip_w    = -E48_MAX;
      eclip_flag = 1'b1;
    end
  end

  // saturating sweep sums
  always_comb begin
    logic signed [65:0] es_ext, cx, s;
    logic [40:0]        ws;
    es_ext = {{2{energy_sum[63]}}, energy_sum};
    cx     = $signed({2'b00, mul_p[79:16]});
    if (!eneg) begin
      s         = es_ext + cx;
      es_sat    = s > ES66_MAX;
      es_next_w = es_sat ? $signed(ljoa_pkg::INT64_MAX) : s[63:0];
    end else begin
      s         = es_ext - cx;
      es_sat    = s < -ES66_MAX;
      es_next_w = es_sat ? -$signed(ljoa_pkg::INT64_MAX) : s[63:0];
    end
    ws        = {1'b0, weight_sum} + {17'd0, w};
    ws_sat    = ws > {1'b0, ljoa_pkg::WMAX};
    ws_next_w = ws_sat ? ljoa_pkg::WMAX : ws[39:0];
  end

  always_comb begin
    logic signed [47:0] a;
    logic [63:0]        m;
    m       = energy_sum[63] ? 64'(-energy_sum) : 64'(energy_sum);
    esmag   = m[62:0];
    avg_sat = div_nq > {16'd0, ljoa_pkg::EMAX};
    a       = avg_sat ? E48_MAX : $signed(div_nq[47:0]);
    avg_w   = energy_sum[63] ? -a : a;
  end

  // multiplier and divider issue
  always_comb begin
    mul_start  = 1'b0;
    mul_a_in   = '0;
    mul_b_in   = '0;
    div_start  = 1'b0;
    div_num_in = '0;
    div_den_in = '0;
    case (state)
      S_COR_P: begin
        mul_start = cor_done;
        mul_a_in  = {40'd0, r};
        mul_b_in  = mag34(st);
      end
      S_RS: begin
        mul_start = mul_done;
        mul_a_in  = mag32(rs_w);
        mul_b_in  = mag34(cp);
      end
      S_PX: begin
        mul_start = mul_done;
        mul_a_in  = mag32(rs);
        mul_b_in  = mag34(sp);
      end
      S_PY: begin
        mul_start = mul_done;
        mul_a_in  = {40'd0, r};
        mul_b_in  = mag34(ct);
      end
      S_SITE: begin
        mul_start = !site_off;
        mul_a_in  = mag32(dx_w);
        mul_b_in  = mag32(dx_w);
      end
      S_DX: begin
        mul_start = mul_done;
        mul_a_in  = mag32(dy_w);
        mul_b_in  = mag32(dy_w);
      end
      S_DY: begin
        mul_start = mul_done;
        mul_a_in  = mag32(dz_w);
        mul_b_in  = mag32(dz_w);
      end
      S_DZ: begin
        mul_start = mul_done;
        mul_a_in  = {44'd0, sig_w};
        mul_b_in  = {44'd0, sig_w};
      end
      S_S2: begin
        div_start  = mul_done && (d2 != 64'd0);
        div_num_in = {10'd0, mul_p[39:0], 30'd0};
        div_den_in = d2;
      end
      S_Q: begin
        mul_start = div_done && !q_sat;
        mul_a_in  = div_nq[63:0];
        mul_b_in  = div_nq[63:0];
      end
      S_Q2: begin
        mul_start = mul_done && !p30_sat;
        mul_a_in  = p30[63:0];
        mul_b_in  = qv;
      end
      S_Q3: begin
        mul_start = mul_done && !p30_sat;
        mul_a_in  = p30[63:0];
        mul_b_in  = p30[63:0];
      end
      S_Q6: begin
        mul_start = mul_done && !p30_sat;
        mul_a_in  = diff_w[63] ? 64'(-diff_w) : 64'(diff_w);
        mul_b_in  = {40'd0, eps_w};
      end
      S_CLIP: begin
        mul_start = 1'b1;
        mul_a_in  = eclip_w[47] ? 64'(-eclip_w) : 64'(eclip_w);
        mul_b_in  = {40'd0, w};
      end
      S_FIN: begin
        div_start  = last && (weight_sum != 40'd0);
        div_num_in = {1'b0, esmag, 16'd0};
        div_den_in = {24'd0, weight_sum};
      end
      default: ;
    endcase
  end

  assign mul_t  = {4'd0, mul_p[127:64]} + ({4'd0, mul_a} * {64'd0, mul_p[3:0]});
  assign div_r2 = {div_rem, div_nq[79]};
  assign div_ge = div_r2 >= {1'b0, div_den};

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_run  <= 1'b0;
      mul_done <= 1'b0;
      mul_cnt  <= 4'd0;
      div_run  <= 1'b0;
      div_done <= 1'b0;
      div_cnt  <= 7'd0;
    end else begin
      mul_done <= 1'b0;
      div_done <= 1'b0;
      if (mul_start) begin
        mul_run <= 1'b1;
        mul_cnt <= 4'd0;
      end else if (mul_run) begin
        mul_cnt <= mul_cnt + 4'd1;
        if (mul_cnt == 4'(ljoa_pkg::MUL_STEPS - 1)) begin
          mul_run  <= 1'b0;
          mul_done <= 1'b1;
        end
      end
      if (div_start) begin
        div_run <= 1'b1;
        div_cnt <= 7'd0;
      end else if (div_run) begin
        div_cnt <= div_cnt + 7'd1;
        if (div_cnt == 7'(ljoa_pkg::DIV_STEPS - 1)) begin
          div_run  <= 1'b0;
          div_done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mul_start) begin
      mul_a <= mul_a_in;
      mul_p <= {64'd0, mul_b_in};
    end else if (mul_run) begin
      mul_p <= {mul_t, mul_p[63:4]};
    end
    if (div_start) begin
      div_den <= div_den_in;
      div_nq  <= div_num_in;
      div_rem <= 64'd0;
    end else if (div_run) begin
      if (div_ge) begin
        div_rem <= 64'(div_r2 - {1'b0, div_den});
        div_nq  <= {div_nq[78:0], 1'b1};
      end else begin
        div_rem <= div_r2[63:0];
        div_nq  <= {div_nq[78:0], 1'b0};
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      energy_sum   <= '0;
      weight_sum   <= '0;
      clip_seen    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready) result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_avail) begin
            r     <= q_head.radius;
            ph    <= q_head.azimuth_angle;
            w     <= q_head.point_weight;
            last  <= q_head.last_point;
            state <= S_COR_T;
          end
        end
        S_COR_T: begin
          if (cor_done) begin
            st    <= cor_sin;
            ct    <= cor_cos;
            state <= S_COR_P;
          end
        end
        S_COR_P: begin
          if (cor_done) begin
            sp    <= cor_sin;
            cp    <= cor_cos;
            state <= S_RS;
          end
        end
        S_RS: begin
          if (mul_done) begin
            rs    <= rs_w;
            state <= S_PX;
          end
        end
        S_PX: begin
          if (mul_done) begin
            px    <= rnd30(rs[31] ^ cp[33], mul_p);
            state <= S_PY;
          end
        end
        S_PY: begin
          if (mul_done) begin
            py    <= rnd30(rs[31] ^ sp[33], mul_p);
            state <= S_PZ;
          end
        end
        S_PZ: begin
          if (mul_done) begin
            pz    <= rnd30(ct[33], mul_p);
            site  <= 2'd0;
            esum  <= '0;
            state <= S_SITE;
          end
        end
        S_SITE: begin
          if (site_off) begin
            site_e <= '0;
            state  <= S_NEXT;
          end else begin
            state <= S_DX;
          end
        end
        S_DX: begin
          if (mul_done) begin
            d2    <= mul_p[63:0];
            state <= S_DY;
          end
        end
        S_DY: begin
          if (mul_done) begin
            d2    <= d2 + mul_p[63:0];
            state <= S_DZ;
          end
        end
        S_DZ: begin
          if (mul_done) begin
            d2    <= d2 + mul_p[63:0];
            state <= S_S2;
          end
        end
        S_S2: begin
          if (mul_done) begin
            if (d2 == 64'd0) begin
              site_e    <= E48_MAX;
              clip_seen <= 1'b1;
              state     <= S_NEXT;
            end else begin
              state <= S_Q;
            end
          end
        end
        S_Q: begin
          if (div_done) begin
            if (q_sat) begin
              site_e    <= E48_MAX;
              clip_seen <= 1'b1;
              state     <= S_NEXT;
            end else begin
              qv    <= div_nq[63:0];
              state <= S_Q2;
            end
          end
        end
        S_Q2: begin
          if (mul_done) begin
            if (p30_sat) begin
              site_e    <= E48_MAX;
              clip_seen <= 1'b1;
              state     <= S_NEXT;
            end else begin
              state <= S_Q3;
            end
          end
        end
        S_Q3: begin
          if (mul_done) begin
            if (p30_sat) begin
              site_e    <= E48_MAX;
              clip_seen <= 1'b1;
              state     <= S_NEXT;
            end else begin
              q3    <= p30[63:0];
              state <= S_Q6;
            end
          end
        end
        S_Q6: begin
          if (mul_done) begin
            if (p30_sat) begin
              site_e    <= E48_MAX;
              clip_seen <= 1'b1;
              state     <= S_NEXT;
            end else begin
              dneg  <= diff_w[63];
              state <= S_E;
            end
          end
        end
        S_E: begin
          if (mul_done) begin
            site_e <= e_w;
            if (e_clip) clip_seen <= 1'b1;
            state <= S_NEXT;
          end
        end
        S_NEXT: begin
          esum <= esum + {{2{site_e[47]}}, site_e};
          if (site == LAST_SITE) begin
            state <= S_CLIP;
          end else begin
            site  <= site + 2'd1;
            state <= S_SITE;
          end
        end
        S_CLIP: begin
          eneg <= eclip_w[47];
          if (eclip_flag) clip_seen <= 1'b1;
          state <= S_C;
        end
        S_C: begin
          if (mul_done) begin
            energy_sum <= es_next_w;
            weight_sum <= ws_next_w;
            if (es_sat || ws_sat) clip_seen <= 1'b1;
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!last) begin
            state <= S_IDLE;
          end else if (weight_sum == 40'd0) begin
            res_avg  <= '0;
            res_zero <= 1'b1;
            state    <= S_OUT;
          end else begin
            res_zero <= 1'b0;
            state    <= S_AVG;
          end
        end
        S_AVG: begin
          if (div_done) begin
            res_avg <= avg_w;
            if (avg_sat) clip_seen <= 1'b1;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            result_valid          <= 1'b1;
            result.average_energy <= res_avg;
            result.zero_weight    <= res_zero;
            result.saturated      <= clip_seen;
            energy_sum            <= '0;
            weight_sum            <= '0;
            clip_seen             <= 1'b0;
            state                 <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(mul_run && div_run))
    else $error("multiplier and divider running together");

  a_mul_done_after_run: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> $past(mul_run))
    else $error("multiplier done without a run");

  a_pop_cordic_free: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !cor_busy)
    else $error("new point taken while cordic busy");

  a_sweep_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_free) |=> (weight_sum == '0 && !clip_seen && result_valid))
    else $error("sweep state not cleared after result");

endmodule

@@ design/lj_orientation_average_core.sv @@
// top level of the orientation-averaged lennard-jones energy core
//
// usage
//   item channel (item_valid / item_ready / item): one quadrature point per
//   transaction: radius, polar and azimuth angle, weight and a last-point flag.
//   result channel (result_valid / result_ready / result): one transaction per
//   sweep, after the point flagged last, carrying the weighted mean energy,
//   a zero-weight flag and a saturation flag.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): register writes,
//   always ready; only to be used while no sweep is in flight.
// datapath
//   points run one at a time through a shared cordic, a four-bit-per-cycle
//   multiplier and a bit-serial divider; the last point adds a final divide
//   before its result appears.
// reset and stalls
//   rst clears the registers, the sums and the queue. a two-entry queue takes
//   points while the back end is busy; a result waiting on result_ready does
//   not hold up the next point until another result is due.
module lj_orientation_average_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  ljoa_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output ljoa_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [23:0]       cfg_data
);

  ljoa_pkg::cfg_t  cfg;
  ljoa_pkg::item_t q_head;
  logic            q_avail;
  logic            q_pop;

  // configuration registers, writes to unused indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        ljoa_pkg::CFG_CENTRE_SITE_Z:         cfg.centre_site_z         <= cfg_data;
        ljoa_pkg::CFG_SIDE_SITE_X:           cfg.side_site_x           <= cfg_data;
        ljoa_pkg::CFG_SIDE_SITE_Z:           cfg.side_site_z           <= cfg_data;
        ljoa_pkg::CFG_CENTRE_SIGMA:          cfg.centre_sigma          <= cfg_data[19:0];
        ljoa_pkg::CFG_CENTRE_EPS_TIMES_FOUR: cfg.centre_eps_times_four <= cfg_data;
        ljoa_pkg::CFG_SIDE_SIGMA:            cfg.side_sigma            <= cfg_data[19:0];
        ljoa_pkg::CFG_SIDE_EPS_TIMES_FOUR:   cfg.side_eps_times_four   <= cfg_data;
        default: ;
      endcase
    end
  end

  // front end: point queue
  ljoa_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .pop        (q_pop),
    .avail      (q_avail),
    .head       (q_head)
  );

  // back end: geometry, site energies, accumulation and the final average
  ljoa_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_avail      (q_avail),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
